[design/glrs_pkg.sv]
`default_nettype none

package glrs_pkg;

    // grid limits and field widths
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int VALUE_BITS    = 4;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
    localparam int SIZE_BITS     = 9;
    localparam int CFG_DATA_BITS = 9;
    localparam int CFG_IDX_BITS  = 1;
    localparam int RISK_BITS     = VALUE_BITS + 1;
    localparam int TOTAL_BITS    = 21;
    localparam int NUM_SLOTS     = 3;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 1'd1;

    // result slots of one transaction, in delivery order
    localparam logic [1:0] SLOT_ABOVE = 2'd0;
    localparam logic [1:0] SLOT_LEFT  = 2'd1;
    localparam logic [1:0] SLOT_SELF  = 2'd2;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [COL_BITS-1:0]   t_col;
    typedef logic [ROW_BITS-1:0]   t_row;
    typedef logic [SIZE_BITS-1:0]  t_size;

    // one line buffer entry: two rows of one column
    typedef struct packed {
        t_value older;
        t_value recent;
    } t_entry;

    // one window cell: rows r-2, r-1 and r of one column
    typedef struct packed {
        t_value rm2;
        t_value rm1;
        t_value r;
    } t_cell;

    typedef struct packed {
        logic rm2;
        logic rm1;
        logic r;
    } t_cell_sel;

    // decided cells of one transaction
    typedef struct packed {
        t_col                   col;
        t_row                   row;
        t_value [NUM_SLOTS-1:0] val;
        logic   [NUM_SLOTS-1:0] low;
    } t_step;

    typedef enum logic [2:0] {
        ST_RD_M2,
        ST_RD_M1,
        ST_RD_C,
        ST_RD_N,
        ST_RUN
    } t_fill_state;

endpackage

`default_nettype wire

[design/glrs_cell.sv]
`default_nettype none

module glrs_cell (
    input  wire logic                i_clk,
    input  wire logic                i_shift,
    input  wire logic                i_load,
    input  wire glrs_pkg::t_cell_sel i_sel,
    input  wire glrs_pkg::t_cell     i_d,
    output glrs_pkg::t_cell          o_q
);
    import glrs_pkg::*;

    t_cell r_q;
    t_cell n_q;

    // shift from the neighbor, or reload selected rows from the line buffer
    always_comb begin
        n_q = r_q;
        if (i_shift) begin
            n_q = i_d;
        end else if (i_load) begin
            if (i_sel.rm2) begin
                n_q.rm2 = i_d.rm2;
            end
            if (i_sel.rm1) begin
                n_q.rm1 = i_d.rm1;
            end
            if (i_sel.r) begin
                n_q.r = i_d.r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

[design/glrs_result.sv]
`default_nettype none

module glrs_result (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    input  wire glrs_pkg::t_step                  i_step,
    input  wire logic [glrs_pkg::NUM_SLOTS-1:0]   i_mask,
    output logic                                  o_can_take,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [glrs_pkg::COL_BITS-1:0]         o_cell_column,
    output logic [glrs_pkg::ROW_BITS-1:0]         o_cell_row,
    output logic                                  o_is_low_point,
    output logic [glrs_pkg::RISK_BITS-1:0]        o_cell_risk,
    output logic [glrs_pkg::TOTAL_BITS-1:0]       o_risk_total,
    output logic                                  o_last_of_run,
    output logic                                  o_frame_done
);
    import glrs_pkg::*;

    t_step                  r_step;
    logic [NUM_SLOTS-1:0]   r_mask;
    logic [TOTAL_BITS-1:0]  r_acc;
    logic                   r_out_valid;
    t_col                   r_out_col;
    t_row                   r_out_row;
    logic                   r_out_low;
    logic [RISK_BITS-1:0]   r_out_risk;
    logic [TOTAL_BITS-1:0]  r_out_total;
    logic                   r_out_last;
    logic                   r_out_done;

    logic                   move;
    logic                   single;
    logic [1:0]             slot;
    logic [NUM_SLOTS-1:0]   slot_bit;
    t_value                 sel_val;
    logic                   sel_low;
    logic [RISK_BITS-1:0]   risk;
    logic [TOTAL_BITS:0]    sum;
    logic [TOTAL_BITS-1:0]  total;
    t_col                   sel_col;
    t_row                   sel_row;

    // pick the earliest pending slot
    always_comb begin
        if (r_mask[SLOT_ABOVE]) begin
            slot = SLOT_ABOVE;
        end else if (r_mask[SLOT_LEFT]) begin
            slot = SLOT_LEFT;
        end else begin
            slot = SLOT_SELF;
        end
        slot_bit       = '0;
        slot_bit[slot] = 1'b1;
    end

    assign single     = (r_mask & (r_mask - NUM_SLOTS'(1))) == '0;
    assign move       = (r_mask != '0) && (!r_out_valid || i_ready);
    assign o_can_take = (r_mask == '0) || (move && single);

    // risk and saturating running total
    always_comb begin
        sel_val = r_step.val[slot];
        sel_low = r_step.low[slot];
        risk    = sel_low ? (RISK_BITS'(sel_val) + RISK_BITS'(1)) : '0;
        sum     = {1'b0, r_acc} + (TOTAL_BITS + 1)'(risk);
        total   = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
        sel_col = (slot == SLOT_LEFT) ? (r_step.col - COL_BITS'(1)) : r_step.col;
        sel_row = (slot == SLOT_ABOVE) ? (r_step.row - ROW_BITS'(1)) : r_step.row;
    end

    // pending slot mask, accumulator and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_mask <= i_mask;
            end else if (move) begin
                r_mask <= r_mask & ~slot_bit;
            end
            if (move) begin
                r_acc <= (slot == SLOT_SELF) ? '0 : total;
            end
            r_out_valid <= move || (r_out_valid && !i_ready);
        end
    end

    // step payload and output register
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_step <= i_step;
        end
        if (move) begin
            r_out_col   <= sel_col;
            r_out_row   <= sel_row;
            r_out_low   <= sel_low;
            r_out_risk  <= risk;
            r_out_total <= total;
            r_out_last  <= single;
            r_out_done  <= (slot == SLOT_SELF);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_cell_column  = r_out_col;
    assign o_cell_row     = r_out_row;
    assign o_is_low_point = r_out_low;
    assign o_cell_risk    = r_out_risk;
    assign o_risk_total   = r_out_total;
    assign o_last_of_run  = r_out_last;
    assign o_frame_done   = r_out_done;

endmodule

`default_nettype wire

[design/grid_local_minimum_risk_sum_top.sv]
`default_nettype none

// Four-neighbor low point detector over a raster stream of heights. One
// transaction is taken per clock while results drain at the same pace and
// the output is not stalled: a cell is reported once its lower neighbor
// arrives, so inputs of the first row give no result and later inputs one,
// inputs of the last row after its first column give two and the final cell
// three; on the last row the input side waits on the single output register
// until the previous transaction's last result moves out. Two earlier rows
// live in a line buffer of MAX_WIDTH entries, read two columns ahead so the
// right neighbor is ready; a chain of three window cells holds the current
// column and the two to its left. After reset and each configuration write
// the block reloads that window from the line buffer before o_ready rises.
// Sizes of 0 act as 1 and sizes above the maximum act as the maximum; the
// running risk total clears after the frame's final cell.
module grid_local_minimum_risk_sum_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [glrs_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [glrs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [glrs_pkg::VALUE_BITS-1:0]     i_height_value,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [glrs_pkg::COL_BITS-1:0]            o_cell_column,
    output logic [glrs_pkg::ROW_BITS-1:0]            o_cell_row,
    output logic                                     o_is_low_point,
    output logic [glrs_pkg::RISK_BITS-1:0]           o_cell_risk,
    output logic [glrs_pkg::TOTAL_BITS-1:0]          o_risk_total,
    output logic                                     o_last_of_run,
    output logic                                     o_frame_done
);
    import glrs_pkg::*;

    t_size        r_grid_width;
    t_size        r_grid_height;
    t_col         r_col;
    t_row         r_row;
    t_fill_state  r_state;
    t_fill_state  n_state;
    t_entry       line_mem [MAX_WIDTH];
    t_entry       r_rd_data;
    t_entry       r_fwd_data;
    logic         r_fwd;

    t_size        w_eff;
    t_size        h_eff;
    t_col         col_cur;
    t_row         row_cur;
    logic         last_col;
    logic         last_row;
    t_col         col_n1;
    t_col         col_n2;
    logic         accept;
    logic         can_take;
    logic         rd_en;
    t_col         rd_addr;
    t_entry       lead;
    t_entry       wdata;
    t_value       v;

    t_cell        cell0_q;
    t_cell        cell1_q;
    t_cell        cell2_q;
    t_cell        cell0_d;
    t_cell        cell1_d;
    t_cell        cell2_d;
    t_cell_sel    sel0;
    t_cell_sel    sel1;
    t_cell_sel    sel2;
    logic         load0;
    logic         load1;
    logic         load2;

    t_step                 step;
    logic [NUM_SLOTS-1:0]  mask;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= SIZE_BITS'(MAX_WIDTH);
            r_grid_height <= SIZE_BITS'(MAX_HEIGHT);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_grid_width  <= SIZE_BITS'(i_cfg_data);
                REG_GRID_HEIGHT: r_grid_height <= SIZE_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // effective size and clamped position
    always_comb begin
        if (r_grid_width == '0) begin
            w_eff = SIZE_BITS'(1);
        end else if (r_grid_width > SIZE_BITS'(MAX_WIDTH)) begin
            w_eff = SIZE_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_grid_width;
        end
        if (r_grid_height == '0) begin
            h_eff = SIZE_BITS'(1);
        end else if (r_grid_height > SIZE_BITS'(MAX_HEIGHT)) begin
            h_eff = SIZE_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = r_grid_height;
        end
        col_cur  = ({1'b0, r_col} < w_eff) ? r_col : COL_BITS'(w_eff - SIZE_BITS'(1));
        row_cur  = ({1'b0, r_row} < h_eff) ? r_row : ROW_BITS'(h_eff - SIZE_BITS'(1));
        last_col = ({1'b0, col_cur} == (w_eff - SIZE_BITS'(1)));
        last_row = ({1'b0, row_cur} == (h_eff - SIZE_BITS'(1)));
        col_n1   = last_col ? '0 : (col_cur + COL_BITS'(1));
        col_n2   = ({1'b0, col_n1} == (w_eff - SIZE_BITS'(1))) ? '0
                                                              : (col_n1 + COL_BITS'(1));
    end

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == ST_RUN) && can_take;
    assign v       = i_height_value;
    assign lead    = r_fwd ? r_fwd_data : r_rd_data;
    assign wdata   = '{older: cell0_q.rm1, recent: v};

    // window reload sequencer: next state
    always_comb begin
        n_state = r_state;
        if (i_cfg_wr_en) begin
            n_state = ST_RD_M2;
        end else begin
            case (r_state)
                ST_RD_M2: n_state = ST_RD_M1;
                ST_RD_M1: n_state = ST_RD_C;
                ST_RD_C:  n_state = ST_RD_N;
                ST_RD_N:  n_state = ST_RUN;
                ST_RUN:   n_state = ST_RUN;
                default:  n_state = ST_RD_M2;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RD_M2;
        end else begin
            r_state <= n_state;
        end
    end

    // window reload sequencer: read address and cell loads
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = col_cur;
        load0   = 1'b0;
        load1   = 1'b0;
        load2   = 1'b0;
        case (r_state)
            ST_RD_M2: begin
                rd_addr = col_cur - COL_BITS'(2);
            end
            ST_RD_M1: begin
                rd_addr = col_cur - COL_BITS'(1);
                load2   = 1'b1;
            end
            ST_RD_C: begin
                rd_addr = col_cur;
                load1   = 1'b1;
            end
            ST_RD_N: begin
                rd_addr = col_n1;
                load0   = 1'b1;
            end
            ST_RUN: begin
                rd_en   = accept;
                rd_addr = col_n2;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // line buffer, read two columns ahead
    always_ff @(posedge i_clk) begin
        if (accept) begin
            line_mem[col_cur] <= wdata;
        end
        if (rd_en) begin
            r_rd_data <= line_mem[rd_addr];
        end
        if (accept) begin
            r_fwd_data <= wdata;
        end
    end

    // bypass when the column read ahead is the one being written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (rd_en) begin
            r_fwd <= accept && (col_n2 == col_cur);
        end
    end

    // window cell inputs
    always_comb begin
        sel0 = '{rm2: 1'b1, rm1: 1'b1, r: 1'b0};
        sel1 = '{rm2: 1'b0, rm1: 1'b1, r: 1'b0};
        sel2 = '{rm2: 1'b0, rm1: 1'b0, r: 1'b1};
        if (accept && (col_n1 == col_cur)) begin
            cell0_d = '{rm2: cell0_q.rm1, rm1: v, r: '0};
        end else begin
            cell0_d = '{rm2: lead.older, rm1: lead.recent, r: '0};
        end
        if (accept) begin
            cell1_d = '{rm2: cell0_q.rm2, rm1: cell0_q.rm1, r: v};
            cell2_d = cell1_q;
        end else begin
            cell1_d = '{rm2: '0, rm1: r_rd_data.older, r: '0};
            cell2_d = '{rm2: '0, rm1: '0, r: r_rd_data.recent};
        end
    end

    // cell chain: current column, one left, two left
    glrs_cell u_cell0 (
        .i_clk   (i_clk),
        .i_shift (accept),
        .i_load  (load0),
        .i_sel   (sel0),
        .i_d     (cell0_d),
        .o_q     (cell0_q)
    );

    glrs_cell u_cell1 (
        .i_clk   (i_clk),
        .i_shift (accept),
        .i_load  (load1),
        .i_sel   (sel1),
        .i_d     (cell1_d),
        .o_q     (cell1_q)
    );

    glrs_cell u_cell2 (
        .i_clk   (i_clk),
        .i_shift (accept),
        .i_load  (load2),
        .i_sel   (sel2),
        .i_d     (cell2_d),
        .o_q     (cell2_q)
    );

    // decisions for the cell above, the cell to the left and the input cell
    always_comb begin
        mask[SLOT_ABOVE] = (row_cur != '0);
        mask[SLOT_LEFT]  = last_row && (col_cur != '0);
        mask[SLOT_SELF]  = last_row && last_col;

        step.col = col_cur;
        step.row = row_cur;

        step.val[SLOT_ABOVE] = cell0_q.rm1;
        step.low[SLOT_ABOVE] = (cell0_q.rm1 < v)
            && ((row_cur <= ROW_BITS'(1)) || (cell0_q.rm1 < cell0_q.rm2))
            && ((col_cur == '0) || (cell0_q.rm1 < cell1_q.rm1))
            && (last_col || (cell0_q.rm1 < lead.recent));

        step.val[SLOT_LEFT] = cell1_q.r;
        step.low[SLOT_LEFT] = (cell1_q.r < v)
            && ((col_cur <= COL_BITS'(1)) || (cell1_q.r < cell2_q.r))
            && ((row_cur == '0) || (cell1_q.r < cell1_q.rm1));

        step.val[SLOT_SELF] = v;
        step.low[SLOT_SELF] = ((col_cur == '0) || (v < cell1_q.r))
            && ((row_cur == '0) || (v < cell0_q.rm1));
    end

    // raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : (row_cur + ROW_BITS'(1));
            end else begin
                r_col <= col_cur + COL_BITS'(1);
                r_row <= row_cur;
            end
        end
    end

    glrs_result u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (accept && (mask != '0)),
        .i_step         (step),
        .i_mask         (mask),
        .o_can_take     (can_take),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cell_column  (o_cell_column),
        .o_cell_row     (o_cell_row),
        .o_is_low_point (o_is_low_point),
        .o_cell_risk    (o_cell_risk),
        .o_risk_total   (o_risk_total),
        .o_last_of_run  (o_last_of_run),
        .o_frame_done   (o_frame_done)
    );

endmodule

`default_nettype wire

[design/glrs_checker.sv]
`default_nettype none

module glrs_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_cfg_wr_en,
    input wire logic                                o_ready,
    input wire logic                                o_valid,
    input wire logic                                i_ready,
    input wire logic                                o_is_low_point,
    input wire logic [glrs_pkg::RISK_BITS-1:0]      o_cell_risk,
    input wire logic [glrs_pkg::TOTAL_BITS-1:0]     o_risk_total,
    input wire logic                                o_last_of_run,
    input wire logic                                o_frame_done
);

    // a stalled result keeps its total
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_risk_total))
        else $error("stalled result changed");

    // the frame's final cell ends its transaction's run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_last_of_run)
        else $error("frame end not last of run");

    // risk is nonzero exactly for low points
    a_risk_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_low_point == (o_cell_risk != '0)))
        else $error("risk and low flag disagree");

    // a nonzero risk shows up in the total
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_cell_risk != '0) |-> (o_risk_total != '0))
        else $error("total misses risk");

    // the window reload holds off input after a register write
    a_cfg_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> !o_ready)
        else $error("input taken during reload");

endmodule

bind grid_local_minimum_risk_sum_top glrs_checker u_glrs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_wr_en    (i_cfg_wr_en),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_is_low_point (o_is_low_point),
    .o_cell_risk    (o_cell_risk),
    .o_risk_total   (o_risk_total),
    .o_last_of_run  (o_last_of_run),
    .o_frame_done   (o_frame_done)
);

`default_nettype wire

[tb/sv/tb_top.sv]
module tb_top;
    import glrs_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 100;
    localparam int REPORT_LIMIT  = 10;

    // traffic shapes for the two handshakes
    typedef enum int {
        TRAFFIC_NONE,
        TRAFFIC_SENDER_IDLE,
        TRAFFIC_RECEIVER_STALL,
        TRAFFIC_BOTH
    } t_traffic;

    // one decided cell as seen on the output ports
    typedef struct packed {
        t_col                  col;
        t_row                  row;
        logic                  low;
        logic [RISK_BITS-1:0]  risk;
        logic [TOTAL_BITS-1:0] total;
        logic                  last;
        logic                  done;
    } t_cell_report;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     i_valid;
    logic                     o_ready;
    logic [VALUE_BITS-1:0]    i_height_value;
    logic                     o_valid;
    logic                     i_ready;
    logic [COL_BITS-1:0]      o_cell_column;
    logic [ROW_BITS-1:0]      o_cell_row;
    logic                     o_is_low_point;
    logic [RISK_BITS-1:0]     o_cell_risk;
    logic [TOTAL_BITS-1:0]    o_risk_total;
    logic                     o_last_of_run;
    logic                     o_frame_done;

    // expected decided cells, oldest first
    t_cell_report expected_cells[$];

    // predictor state: two line buffers, left neighbor, position, sum, sizes
    t_value                older_rows[MAX_WIDTH];
    t_value                recent_rows[MAX_WIDTH];
    t_value                prev_height;
    int                    col_pos;
    int                    row_pos;
    logic [TOTAL_BITS-1:0] risk_sum;
    t_size                 cfg_width;
    t_size                 cfg_height;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int heights_sent;
    int cycle_count;

    grid_local_minimum_risk_sum_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_height_value (i_height_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cell_column  (o_cell_column),
        .o_cell_row     (o_cell_row),
        .o_is_low_point (o_is_low_point),
        .o_cell_risk    (o_cell_risk),
        .o_risk_total   (o_risk_total),
        .o_last_of_run  (o_last_of_run),
        .o_frame_done   (o_frame_done)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // effective grid size: zero acts as one, oversize acts as the maximum
    function automatic int clamp_size(input t_size v, input int max_size);
        if (v == 0) return 1;
        if (int'(v) > max_size) return max_size;
        return int'(v);
    endfunction

    // add one decided cell to the running sum and to the expected queue
    function automatic void record_cell(input int col, input int row, input t_value height,
                                        input logic low, input logic done);
        t_cell_report rec;
        int risk;
        risk = low ? int'(height) + 1 : 0;
        if (int'(risk_sum) > int'(TOTAL_MAX) - risk)
            risk_sum = TOTAL_MAX;
        else
            risk_sum = risk_sum + TOTAL_BITS'(risk);
        rec.col   = t_col'(col);
        rec.row   = t_row'(row);
        rec.low   = low;
        rec.risk  = RISK_BITS'(risk);
        rec.total = risk_sum;
        rec.last  = 1'b0;
        rec.done  = done;
        expected_cells = {expected_cells, rec};
    endfunction

    // decide every cell whose neighbors are complete once this height arrives
    function automatic void predict_cells(input t_value v);
        int     w, h, c, r, n;
        logic   last_col, last_row, low;
        t_value above, left;
        w = clamp_size(cfg_width, MAX_WIDTH);
        h = clamp_size(cfg_height, MAX_HEIGHT);
        c = (col_pos < w) ? col_pos : w - 1;
        r = (row_pos < h) ? row_pos : h - 1;
        last_col = (c == w - 1);
        last_row = (r == h - 1);
        n = 0;

        // cell above the input now has its lower neighbor
        if (r > 0) begin
            above = recent_rows[c];
            low = above < v;
            if (r > 1 && !(above < older_rows[c])) low = 1'b0;
            if (c > 0 && !(above < older_rows[c-1])) low = 1'b0;
            if (!last_col && !(above < recent_rows[c+1])) low = 1'b0;
            record_cell(c, r - 1, above, low, 1'b0);
            n++;
        end

        older_rows[c]  = recent_rows[c];
        recent_rows[c] = v;

        // on the last row the left neighbor is complete too
        if (last_row && c > 0) begin
            left = prev_height;
            low = left < v;
            if (c > 1 && !(left < recent_rows[c-2])) low = 1'b0;
            if (r > 0 && !(left < older_rows[c-1])) low = 1'b0;
            record_cell(c - 1, r, left, low, 1'b0);
            n++;
        end

        // final cell of the grid decides itself
        if (last_row && last_col) begin
            low = 1'b1;
            if (c > 0 && !(v < prev_height)) low = 1'b0;
            if (r > 0 && !(v < older_rows[c])) low = 1'b0;
            record_cell(c, r, v, low, 1'b1);
            n++;
        end

        prev_height = v;
        if (last_col) begin
            col_pos = 0;
            if (last_row) begin
                row_pos  = 0;
                risk_sum = '0;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end

        if (n > 0)
            expected_cells[expected_cells.size()-1].last = 1'b1;
    endfunction

    // receiver side stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void report_mismatch(input string what, input t_cell_report want,
                                            input t_cell_report got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s at cycle %0d: expected col %0d row %0d low %0b risk %0d total %0d",
                     what, cycle_count, want.col, want.row, want.low, want.risk, want.total);
            $display("    expected last %0b done %0b, got col %0d row %0d low %0b risk %0d",
                     want.last, want.done, got.col, got.row, got.low, got.risk);
            $display("    got total %0d last %0b done %0b",
                     got.total, got.last, got.done);
        end
    endfunction

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_cell_report got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_cell_column, o_cell_row, o_is_low_point, o_cell_risk,
                    o_risk_total, o_last_of_run, o_frame_done};
            if (expected_cells.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = expected_cells.pop_front();
                if (got !== want)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("grid_local_minimum_risk_sum_top regression: fail");
        $finish;
    end

    task automatic set_traffic(input t_traffic mode);
        case (mode)
            TRAFFIC_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            TRAFFIC_SENDER_IDLE: begin
                send_idle_pct  = 76;
                recv_stall_pct = 0;
            end
            TRAFFIC_RECEIVER_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 76;
            end
            default: begin
                send_idle_pct  = 14;
                recv_stall_pct = 14;
            end
        endcase
    endtask

    // one input transaction, predicted at acceptance
    task automatic send_height(input t_value v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_height_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_cells(v);
        heights_sent++;
    endtask

    task automatic send_heights(input t_value seq[$]);
        foreach (seq[k]) send_height(seq[k]);
    endtask

    // random heights until the grid position wraps back to the origin
    task automatic send_rest_of_frame(input int base, input int spread);
        do begin
            send_height(t_value'(base + $urandom_range(spread)));
        end while (col_pos != 0 || row_pos != 0);
    endtask

    // stop sending, let every expected result arrive and the block settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid(input t_size width, input t_size height);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_GRID_WIDTH;
        i_cfg_data  <= width;
        @(posedge i_clk);
        cfg_width = width;
        i_cfg_index <= REG_GRID_HEIGHT;
        i_cfg_data  <= height;
        @(posedge i_clk);
        cfg_height = height;
        i_cfg_wr_en <= 1'b0;
    endtask

    // zero sizes act as a 1x1 grid: every cell is a low point
    task automatic test_single_cell();
        t_value seq[$];
        set_traffic(TRAFFIC_NONE);
        set_grid(9'd0, 9'd0);
        seq = {4'd0, 4'd15, 4'd8};
        send_heights(seq);
    endtask

    // 3x3 with two corner lows, a tie and both value extremes
    task automatic test_three_by_three();
        t_value seq[$];
        set_traffic(TRAFFIC_BOTH);
        set_grid(9'd3, 9'd3);
        seq = {4'd1, 4'd5, 4'd0,
               4'd9, 4'd6, 4'd9,
               4'd4, 4'd4, 4'd15};
        send_heights(seq);
    endtask

    // one row: only left and right neighbors exist
    task automatic test_single_row();
        t_value seq[$];
        set_traffic(TRAFFIC_RECEIVER_STALL);
        set_grid(9'd4, 9'd1);
        seq = {4'd3, 4'd1, 4'd2, 4'd0};
        send_heights(seq);
    endtask

    // one column: only up and down neighbors exist
    task automatic test_single_column();
        t_value seq[$];
        set_traffic(TRAFFIC_SENDER_IDLE);
        set_grid(9'd1, 9'd4);
        seq = {4'd7, 4'd2, 4'd2, 4'd15};
        send_heights(seq);
    endtask

    // oversize width acts as the full line buffer
    task automatic test_full_width_row();
        t_value seq[$];
        set_traffic(TRAFFIC_BOTH);
        set_grid(9'd511, 9'd1);
        send_rest_of_frame(0, 15);
        set_traffic(TRAFFIC_NONE);
        set_grid(9'd256, 9'd2);
        seq = {4'd15, 4'd0};
        send_heights(seq);
        set_grid(9'd2, 9'd2);
        send_rest_of_frame(0, 15);
    endtask

    // shrink the grid while a frame is in progress; position clamps
    task automatic test_resize_mid_frame();
        int k;
        set_traffic(TRAFFIC_BOTH);
        set_grid(9'd1, 9'd300);
        for (k = 0; k < 20; k++) send_height(t_value'($urandom_range(15)));
        set_grid(9'd1, 9'd8);
        send_rest_of_frame(0, 15);

        set_traffic(TRAFFIC_RECEIVER_STALL);
        set_grid(9'd20, 9'd3);
        for (k = 0; k < 15; k++) send_height(t_value'($urandom_range(15)));
        set_grid(9'd6, 9'd3);
        send_rest_of_frame(0, 15);
    endtask

    // random small grids, full range or narrow range heights for many ties
    task automatic test_random_frames();
        int start_count, frame_idx, spread, base;
        start_count = heights_sent;
        frame_idx   = 0;
        while (heights_sent - start_count < RANDOM_ITEMS) begin
            set_traffic(t_traffic'(frame_idx % 4));
            set_grid(t_size'($urandom_range(12)), t_size'($urandom_range(8)));
            spread = ($urandom_range(1) == 1) ? 15 : $urandom_range(1, 3);
            base   = $urandom_range(15 - spread);
            send_rest_of_frame(base, spread);
            frame_idx++;
        end
    endtask

    // main sequence
    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_index    <= REG_GRID_WIDTH;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_height_value <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        heights_sent   = 0;
        foreach (older_rows[k]) begin
            older_rows[k]  = '0;
            recent_rows[k] = '0;
        end
        prev_height = '0;
        col_pos     = 0;
        row_pos     = 0;
        risk_sum    = '0;
        cfg_width   = 9'd256;
        cfg_height  = 9'd256;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_cell();
        test_three_by_three();
        test_single_row();
        test_single_column();
        test_resize_mid_frame();
        test_full_width_row();
        test_random_frames();

        wait_idle();
        if (mismatch_count == 0)
            $display("grid_local_minimum_risk_sum_top regression: pass");
        else
            $display("grid_local_minimum_risk_sum_top regression: fail");
        $finish;
    end

endmodule

[sim.f]
design/glrs_pkg.sv
design/glrs_cell.sv
design/glrs_result.sv
design/grid_local_minimum_risk_sum_top.sv
design/glrs_checker.sv
tb/sv/tb_top.sv
